### rtl/fpvn_pkg.sv
// Package: payload types and constants for the fixed-point vector normalizer
`default_nettype none
package fpvn_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CW            = 32;  // component width
  localparam int QW            = 17;  // reciprocal width, floor(2^16 / root)

  typedef struct packed {
    logic signed [CW-1:0] vec_x;
    logic signed [CW-1:0] vec_y;
    logic signed [CW-1:0] vec_z;
  } vec_in_t;

  typedef struct packed {
    logic signed [CW-1:0] norm_x;
    logic signed [CW-1:0] norm_y;
    logic signed [CW-1:0] norm_z;
  } vec_out_t;

endpackage
`default_nettype wire

### rtl/fixed_point_vector_normalize.sv
// Throughput: one vector per cycle; the square root runs one result bit per stage
// and the reciprocal one quotient bit per stage, all stages advancing together.
// A result held at the output stalls every stage; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears every valid bit; payload is not reset.
`default_nettype none
module fixed_point_vector_normalize #(
  parameter int FRAC_BITS = fpvn_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire fpvn_pkg::vec_in_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output fpvn_pkg::vec_out_t      out_data
);
  import fpvn_pkg::*;

  localparam int IW = CW - FRAC_BITS;   // integer-part magnitude width
  localparam int SW = 2 * IW;           // sum of squares width
  localparam int RW = IW;               // root width
  localparam int P  = 3 + RW + QW + 1;  // stages before the output register
  localparam int PM = 50;               // product width, 32 x 18 signed

  logic en;
  logic out_valid_r;
  vec_out_t out_data_r;

  // carried along every stage
  logic    vld_r [P];
  vec_in_t cv_r  [P];
  logic    zf_r  [P];

  logic [IW-1:0] mag_r [3];
  logic [SW-1:0] sq_r  [3];
  logic [SW-1:0] sum_r;

  logic [SW-1:0]   rt_rad_r  [RW];
  logic [RW+1:0]   rt_rem_r  [RW];
  logic [RW-1:0]   rt_root_r [RW];
  logic [RW:0]     dv_rem_r  [QW];
  logic [QW-1:0]   dv_q_r    [QW];
  logic [RW-1:0]   dv_root_r [QW];
  logic signed [PM-1:0] prod_r [3];

  // advance whenever the output register is free or being taken
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < P; p++) vld_r[p] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int p = 1; p < P; p++) vld_r[p] <= vld_r[p-1];
      out_valid_r <= vld_r[P-1];
    end
  end

  // stage 0: integer parts and magnitudes
  logic signed [CW-1:0] ip_nxt [3];
  logic [CW-1:0]        ab_nxt [3];
  always_comb begin
    ip_nxt[0] = in_data.vec_x >>> FRAC_BITS;
    ip_nxt[1] = in_data.vec_y >>> FRAC_BITS;
    ip_nxt[2] = in_data.vec_z >>> FRAC_BITS;
    for (int i = 0; i < 3; i++)
      ab_nxt[i] = ip_nxt[i][CW-1] ? CW'(-ip_nxt[i]) : CW'(ip_nxt[i]);
  end

  // capture and carry the original vector and zero flag
  always_ff @(posedge clk) begin
    if (en) begin
      cv_r[0] <= in_data;
      zf_r[0] <= (ip_nxt[0] == '0) && (ip_nxt[1] == '0) && (ip_nxt[2] == '0);
      for (int p = 1; p < P; p++) begin
        cv_r[p] <= cv_r[p-1];
        zf_r[p] <= zf_r[p-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) mag_r[i] <= ab_nxt[i][IW-1:0];
    end
  end

  // stage 1: squares; stage 2: sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sq_r[i] <= SW'(mag_r[i] * mag_r[i]);
      sum_r <= sq_r[0] + sq_r[1] + sq_r[2];
    end
  end

  // square root, one result bit per stage
  genvar k;
  generate
    for (k = 0; k < RW; k++) begin : g_rt
      logic [SW-1:0] rad_in;
      logic [RW+1:0] rem_in;
      logic [RW-1:0] root_in;
      logic [RW+1:0] rem_t;
      logic [RW+1:0] trial;
      logic          ge;
      logic [RW+1:0] rem_nxt;
      if (k == 0) begin : g_first
        assign rad_in  = sum_r;
        assign rem_in  = '0;
        assign root_in = '0;
      end else begin : g_next
        assign rad_in  = rt_rad_r[k-1];
        assign rem_in  = rt_rem_r[k-1];
        assign root_in = rt_root_r[k-1];
      end
      assign rem_t   = {rem_in[RW-1:0], rad_in[SW-1:SW-2]};
      assign trial   = {root_in, 2'b01};
      assign ge      = rem_t >= trial;
      assign rem_nxt = ge ? rem_t - trial : rem_t;
      always_ff @(posedge clk) begin
        if (en) begin
          rt_rad_r[k]  <= rad_in << 2;
          rt_rem_r[k]  <= rem_nxt;
          rt_root_r[k] <= {root_in[RW-2:0], ge};
        end
      end
    end
  endgenerate

  // reciprocal floor(2^16 / root), one quotient bit per stage
  generate
    for (k = 0; k < QW; k++) begin : g_dv
      logic [RW:0]   rem_in;
      logic [QW-1:0] q_in;
      logic [RW-1:0] root_in;
      logic [RW:0]   rem_t;
      logic          ge;
      if (k == 0) begin : g_first
        assign rem_in  = '0;
        assign q_in    = '0;
        assign root_in = rt_root_r[RW-1];
      end else begin : g_next
        assign rem_in  = dv_rem_r[k-1];
        assign q_in    = dv_q_r[k-1];
        assign root_in = dv_root_r[k-1];
      end
      // dividend is a single one in its top bit
      assign rem_t = {rem_in[RW-1:0], (k == 0) ? 1'b1 : 1'b0};
      assign ge    = rem_t >= {1'b0, root_in};
      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem_r[k]  <= ge ? rem_t - {1'b0, root_in} : rem_t;
          dv_q_r[k]    <= {q_in[QW-2:0], ge};
          dv_root_r[k] <= root_in;
        end
      end
    end
  endgenerate

  // scale each component
  logic signed [QW:0] scale_s;
  assign scale_s = {1'b0, dv_q_r[QW-1]};
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r[0] <= PM'(cv_r[P-2].vec_x * scale_s);
      prod_r[1] <= PM'(cv_r[P-2].vec_y * scale_s);
      prod_r[2] <= PM'(cv_r[P-2].vec_z * scale_s);
    end
  end

  // shift, wrap, and pick passthrough for zero integer parts
  logic signed [63:0] sh_nxt [3];
  always_comb begin
    for (int i = 0; i < 3; i++)
      sh_nxt[i] = {{(64-PM){prod_r[i][PM-1]}}, prod_r[i]} >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zf_r[P-1]) begin
        out_data_r.norm_x <= cv_r[P-1].vec_x;
        out_data_r.norm_y <= cv_r[P-1].vec_y;
        out_data_r.norm_z <= cv_r[P-1].vec_z;
      end else begin
        out_data_r.norm_x <= sh_nxt[0][CW-1:0];
        out_data_r.norm_y <= sh_nxt[1][CW-1:0];
        out_data_r.norm_z <= sh_nxt[2][CW-1:0];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // zero flag agrees with the sum of squares
  a_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] |-> ((sum_r == '0) == zf_r[2]))
    else $error("zero flag disagrees with sum of squares");

  // a stalled pipeline keeps its first and last valid bits
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> (vld_r[P-1] == $past(vld_r[P-1])) && (vld_r[0] == $past(vld_r[0])))
    else $error("valid bit changed during stall");

  // the last stage drains into the output register
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_r[P-1] |=> out_valid)
    else $error("result lost at output register");

endmodule
`default_nettype wire

### bench/tb_fixed_point_vector_normalize.sv
// Testbench for the fixed-point vector normalizer: directed table plus random vectors
`default_nettype none
module tb_fixed_point_vector_normalize;
  import fpvn_pkg::*;

  localparam int FB        = FRAC_BITS_DEF;
  localparam int NUM_RAND  = 1750;
  localparam int LATENCY   = 3 + (32 - FB) + 17 + 2;
  localparam int MAX_CYCLE = 400000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  vec_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  vec_out_t out_data;

  fixed_point_vector_normalize #(.FRAC_BITS(FB)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // One row of the directed table; has_exp marks a result typed in by hand
  typedef struct {
    logic [CW-1:0] x, y, z;
    bit            has_exp;
    logic [CW-1:0] ex, ey, ez;
  } vec_row_t;

  vec_out_t pending_norms[$];
  int       err_cnt;
  int       cycle_cnt;
  int       sent_cnt;
  int       got_cnt;
  int       unit_cnt;

  // Clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Arithmetic shift right of a signed 64-bit value
  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  // Floor square root, one result bit at a time
  function automatic longint unsigned sqrt_floor(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Normalize one vector
  function automatic vec_out_t normalize_vec(vec_in_t v);
    longint          comp[3];
    longint          ip[3];
    longint unsigned mag, sum, root, divisor, scale;
    longint          prod;
    logic [CW-1:0]   res[3];
    vec_out_t        o;
    comp[0] = longint'(v.vec_x);
    comp[1] = longint'(v.vec_y);
    comp[2] = longint'(v.vec_z);
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      ip[i] = asr(comp[i], FB);
      mag = (ip[i] < 0) ? -ip[i] : ip[i];
      sum += mag * mag;
    end
    // Pass through when every integer part is zero
    if (ip[0] == 0 && ip[1] == 0 && ip[2] == 0) begin
      return vec_out_t'(v);
    end
    root = sqrt_floor(sum);
    divisor = root << (FB - 8);
    if (divisor == 0) divisor = 1;
    scale = (64'd1 << (FB + 8)) / divisor;
    for (int i = 0; i < 3; i++) begin
      prod = comp[i] * longint'(scale);
      res[i] = CW'(asr(prod, FB));
    end
    o.norm_x = res[0];
    o.norm_y = res[1];
    o.norm_z = res[2];
    return o;
  endfunction

  // Random component: a mix of full-range, moderate and near-zero magnitudes
  function automatic logic [CW-1:0] rand_comp();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom;
    if (sel < 6) return $signed($urandom_range(0, 32'h1FFFF)) - 32'sh10000;
    if (sel < 8) return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
    return {{4{$urandom_range(0, 1) == 1}}, 28'($urandom)};
  endfunction

  // Send one transaction after a random gap and record its expected result
  task automatic send_vec(vec_in_t v);
    int gap;
    gap = $urandom_range(0, 3);
    if (sent_cnt % 200 < 20) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_norms.push_back(normalize_vec(v));
    sent_cnt++;
  endtask

  // Drive out_ready with random stalls
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = $urandom_range(0, 3);
      if ((cycle_cnt / 500) % 4 == 0) stall = 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin
    vec_out_t ex;
    if (rst_n && out_valid && out_ready) begin
      got_cnt++;
      if (pending_norms.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result %h", $time, out_data);
      end else begin
        ex = pending_norms.pop_front();
        if (ex.norm_x !== out_data.norm_x) begin
          err_cnt++;
          $display("%0t: norm_x expected %h actual %h", $time, ex.norm_x, out_data.norm_x);
        end
        if (ex.norm_y !== out_data.norm_y) begin
          err_cnt++;
          $display("%0t: norm_y expected %h actual %h", $time, ex.norm_y, out_data.norm_y);
        end
        if (ex.norm_z !== out_data.norm_z) begin
          err_cnt++;
          $display("%0t: norm_z expected %h actual %h", $time, ex.norm_z, out_data.norm_z);
        end
      end
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLE) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Stimulus
  initial begin
    vec_row_t dir_rows[$];
    vec_in_t  v;
    vec_out_t ex;
    int       n_dir;
    err_cnt   = 0;
    cycle_cnt = 0;
    sent_cnt  = 0;
    got_cnt   = 0;
    unit_cnt  = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;

    // Pass-through and unit-axis rows have results typed in; the rest use the predictor
    dir_rows = '{
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
      '{32'h0000_FFFF, 32'h0000_8000, 32'h0000_0001, 1, 32'h0000_FFFF, 32'h0000_8000, 32'h0000_0001},
      '{32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000},
      '{32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 1, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000},
      '{32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000, 1, 32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000},
      '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_0000, 1, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_0000},
      '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 0, 0, 0, 0},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0},
      '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0},
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 0, 0, 0, 0},
      '{32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 0, 0, 0, 0},
      '{32'h0003_0000, 32'h0004_0000, 32'h0000_0000, 0, 0, 0, 0},
      '{32'hFFFD_0000, 32'h0000_0000, 32'hFFFC_0000, 0, 0, 0, 0},
      '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 0, 0},
      '{32'h0002_8000, 32'hFFFE_8000, 32'h0000_FFFF, 0, 0, 0, 0},
      '{32'h0010_0000, 32'h0000_0001, 32'h8000_0001, 0, 0, 0, 0},
      '{32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 0, 0, 0, 0}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (dir_rows[i]) begin
      v.vec_x = dir_rows[i].x;
      v.vec_y = dir_rows[i].y;
      v.vec_z = dir_rows[i].z;
      if (dir_rows[i].has_exp) begin
        ex.norm_x = dir_rows[i].ex;
        ex.norm_y = dir_rows[i].ey;
        ex.norm_z = dir_rows[i].ez;
        if (normalize_vec(v) !== ex) begin
          err_cnt++;
          $display("%0t: table row %0d expected %h actual %h", $time, i, ex, normalize_vec(v));
        end
      end
      send_vec(v);
    end
    in_valid <= 1'b0;
    n_dir = sent_cnt;

    // Hold off until the pipeline drains once
    while (pending_norms.size() != 0) @(posedge clk);

    // Random vectors
    for (int k = 0; k < NUM_RAND; k++) begin
      v.vec_x = rand_comp();
      v.vec_y = rand_comp();
      v.vec_z = rand_comp();
      if ($urandom_range(0, 19) == 0) begin
        v.vec_x = $signed($urandom_range(0, 32'h1FFFF)) - 32'sh10000;
        v.vec_y = $signed($urandom_range(0, 32'h1FFFF)) - 32'sh10000;
        v.vec_z = $signed($urandom_range(0, 32'h1FFFF)) - 32'sh10000;
      end
      if (asr(longint'(v.vec_x), FB) == 0 && asr(longint'(v.vec_y), FB) == 0
          && asr(longint'(v.vec_z), FB) == 0) unit_cnt++;
      send_vec(v);
    end
    in_valid <= 1'b0;

    // Drain and let the pipeline settle
    while (pending_norms.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("covered %0d directed and %0d random vectors, %0d with zero integer parts",
             n_dir, sent_cnt - n_dir, unit_cnt);
    $display("received %0d results, %0d mismatches", got_cnt, err_cnt);
    if (err_cnt == 0 && pending_norms.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
